>>> hdl/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg
// Shared types, constants and helpers of the wide integer ALU.
// ----------------------------------------------------------------------------
package wia_pkg;

   localparam int WORD_BITS = 128;               // operand width, 16 to 128
   localparam int FULL_BITS = 128;               // width of the operand ports
   localparam int HALF_BITS = FULL_BITS / 2;
   localparam int AMT_BITS  = 8;
   localparam int LIMB_BITS = 32;
   localparam int LIMBS     = FULL_BITS / LIMB_BITS;
   localparam int MUL_LAT   = 3;
   localparam int DIV_LAT   = WORD_BITS + 2;     // prep, one step per bit, fixup

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_NEG = 4'd2,
      OP_MUL = 4'd3,
      OP_DIV = 4'd4,
      OP_MOD = 4'd5,
      OP_AND = 4'd6,
      OP_OR  = 4'd7,
      OP_XOR = 4'd8,
      OP_NOT = 4'd9,
      OP_SHL = 4'd10,
      OP_SAR = 4'd11,
      OP_ROL = 4'd12,
      OP_ROR = 4'd13,
      OP_CMP = 4'd14,
      OP_NOP = 4'd15
   } alu_op_type;

   typedef struct packed {
      logic [3:0]           req_type;
      logic [HALF_BITS-1:0] a_low;
      logic [HALF_BITS-1:0] a_high;
      logic [HALF_BITS-1:0] b_low;
      logic [HALF_BITS-1:0] b_high;
      logic [AMT_BITS-1:0]  shift_amount;
   } alu_req_type;

   typedef struct packed {
      logic [HALF_BITS-1:0] result_low;
      logic [HALF_BITS-1:0] result_high;
      logic                 is_less;
      logic                 is_equal;
      logic                 divide_by_zero;
   } alu_rsp_type;

   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic div_zero;
   } div_side_type;

   typedef struct packed {
      word_type result;
      logic     is_less;
      logic     is_equal;
   } simp_type;

   // amount modulo WORD_BITS by conditional subtraction
   function automatic logic [AMT_BITS-1:0] rot_amount(input logic [AMT_BITS-1:0] amt);
      logic [10:0] r;
      r = {3'b000, amt};
      for (int k = 3; k >= 0; k--) begin
         if (r >= 11'(WORD_BITS << k)) begin
            r = r - 11'(WORD_BITS << k);
         end
      end
      return r[AMT_BITS-1:0];
   endfunction

endpackage

>>> hdl/wia_mul.sv
// ----------------------------------------------------------------------------
// wia_mul
// Three-stage multiplier keeping the low word of the product.
// ----------------------------------------------------------------------------
module wia_mul (
   input  logic              clock,
   input  logic              enable,
   input  wia_pkg::word_type a_in,
   input  wia_pkg::word_type b_in,
   output wia_pkg::word_type product
);
   import wia_pkg::*;

   logic [FULL_BITS-1:0]     a_full;
   logic [FULL_BITS-1:0]     b_full;
   logic [2*LIMB_BITS-1:0]   pp_ff [LIMBS][LIMBS];
   logic [2*LIMB_BITS+1:0]   diag_in [LIMBS];
   logic [2*LIMB_BITS+1:0]   diag_ff [LIMBS];
   logic [FULL_BITS-1:0]     prod_in;
   logic [FULL_BITS-1:0]     prod_ff;

   assign a_full = FULL_BITS'(a_in);
   assign b_full = FULL_BITS'(b_in);

   // partial products below the word boundary only
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
               if (i + j < LIMBS) begin
                  pp_ff[i][j] <= a_full[i*LIMB_BITS +: LIMB_BITS]
                               * b_full[j*LIMB_BITS +: LIMB_BITS];
               end else begin
                  pp_ff[i][j] <= '0;
               end
            end
         end
      end
   end

   // sum each diagonal of equal weight
   always_comb begin
      for (int k = 0; k < LIMBS; k++) begin
         diag_in[k] = '0;
         for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
               if (i + j == k) begin
                  diag_in[k] = diag_in[k] + (2*LIMB_BITS+2)'(pp_ff[i][j]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diag_ff <= diag_in;
      end
   end

   always_comb begin
      prod_in = '0;
      for (int k = 0; k < LIMBS; k++) begin
         prod_in = prod_in + (FULL_BITS'(diag_ff[k]) << (k * LIMB_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff[WORD_BITS-1:0];

endmodule

>>> hdl/wia_div.sv
// ----------------------------------------------------------------------------
// wia_div
// Pipelined signed restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wia_div (
   input  logic              clock,
   input  logic              enable,
   input  wia_pkg::word_type a_in,
   input  wia_pkg::word_type b_in,
   output wia_pkg::word_type quotient,
   output wia_pkg::word_type remainder,
   output logic              div_zero
);
   import wia_pkg::*;

   word_type     rem_ff  [WORD_BITS+1];
   word_type     nq_ff   [WORD_BITS+1];
   word_type     d_ff    [WORD_BITS+1];
   div_side_type side_ff [WORD_BITS+1];
   div_side_type side_in;
   word_type     mag_a;
   word_type     mag_b;
   word_type     quo_ff;
   word_type     rmd_ff;
   logic         dz_ff;
   word_type     q_last;
   word_type     r_last;

   assign side_in.neg_a    = a_in[WORD_BITS-1];
   assign side_in.neg_b    = b_in[WORD_BITS-1];
   assign side_in.div_zero = (b_in == '0);
   assign mag_a = side_in.neg_a ? (~a_in) + word_type'(1) : a_in;
   assign mag_b = side_in.neg_b ? (~b_in) + word_type'(1) : b_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= '0;
         nq_ff[0]   <= mag_a;
         d_ff[0]    <= mag_b;
         side_ff[0] <= side_in;
      end
   end

   // a zero divisor leaves the dividend magnitude in the remainder
   for (genvar s = 1; s <= WORD_BITS; s++) begin : g_step
      logic [WORD_BITS:0] t_val;
      logic [WORD_BITS:0] diff_val;
      logic               ge;

      assign t_val    = {rem_ff[s-1], nq_ff[s-1][WORD_BITS-1]};
      assign diff_val = t_val - {1'b0, d_ff[s-1]};
      assign ge       = (t_val >= {1'b0, d_ff[s-1]});

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= ge ? diff_val[WORD_BITS-1:0] : t_val[WORD_BITS-1:0];
            nq_ff[s]   <= {nq_ff[s-1][WORD_BITS-2:0], ge};
            d_ff[s]    <= d_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign q_last = nq_ff[WORD_BITS];
   assign r_last = rem_ff[WORD_BITS];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (side_ff[WORD_BITS].div_zero) begin
            quo_ff <= '0;
         end else if (side_ff[WORD_BITS].neg_a ^ side_ff[WORD_BITS].neg_b) begin
            quo_ff <= (~q_last) + word_type'(1);
         end else begin
            quo_ff <= q_last;
         end
         rmd_ff <= side_ff[WORD_BITS].neg_a ? (~r_last) + word_type'(1) : r_last;
         dz_ff  <= side_ff[WORD_BITS].div_zero;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rmd_ff;
   assign div_zero  = dz_ff;

endmodule

>>> hdl/wide_integer_alu_128.sv
// An accepted item passes the input register, the divider stages and the result register.
// Throughput: one item per cycle while the result is not stalled; the divider has one stage per quotient bit.
// A stalled result holds the whole pipeline in place; nothing is dropped.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// wide_integer_alu_128
// Pipelined 128-bit two's complement ALU with multiply and divide.
// ----------------------------------------------------------------------------
module wide_integer_alu_128 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wia_pkg::alu_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wia_pkg::alu_rsp_type rsp_data
);
   import wia_pkg::*;

   logic          adv;
   logic          s0_valid_ff;
   alu_req_type   s0_req_ff;
   logic [FULL_BITS-1:0] a_full;
   logic [FULL_BITS-1:0] b_full;
   word_type      a_w;
   word_type      b_w;
   alu_op_type    op;
   logic [AMT_BITS-1:0] amt;
   logic [AMT_BITS-1:0] rot_n;
   logic [AMT_BITS-1:0] sar_n;
   logic [2*WORD_BITS-1:0] dbl;
   logic [2*WORD_BITS-1:0] rol_val;
   logic [2*WORD_BITS-1:0] ror_val;
   simp_type      simp_in;

   logic          vld_dly_ff  [DIV_LAT];
   alu_op_type    op_dly_ff   [DIV_LAT];
   simp_type      simp_dly_ff [DIV_LAT];
   word_type      mul_dly_ff  [DIV_LAT-MUL_LAT];

   word_type      mul_out;
   word_type      div_quo;
   word_type      div_rem;
   logic          div_dz;

   alu_op_type    op_last;
   word_type      sel_word;
   logic [FULL_BITS-1:0] full_res;
   alu_rsp_type   rsp_data_in;
   alu_rsp_type   rsp_data_ff;
   logic          rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_req_ff <= req_data;
      end
   end

   assign a_full = {s0_req_ff.a_high, s0_req_ff.a_low};
   assign b_full = {s0_req_ff.b_high, s0_req_ff.b_low};
   assign a_w    = a_full[WORD_BITS-1:0];
   assign b_w    = b_full[WORD_BITS-1:0];
   assign op     = alu_op_type'(s0_req_ff.req_type);
   assign amt    = s0_req_ff.shift_amount;
   assign rot_n  = rot_amount(amt);
   assign sar_n  = (amt >= AMT_BITS'(WORD_BITS)) ? AMT_BITS'(WORD_BITS - 1) : amt;
   assign dbl    = {a_w, a_w};
   assign rol_val = dbl << rot_n;
   assign ror_val = dbl >> rot_n;

   always_comb begin
      simp_in.is_less  = 1'b0;
      simp_in.is_equal = 1'b0;
      unique case (op)
         OP_ADD: simp_in.result = a_w + b_w;
         OP_SUB: simp_in.result = a_w - b_w;
         OP_NEG: simp_in.result = word_type'(0) - a_w;
         OP_AND: simp_in.result = a_w & b_w;
         OP_OR:  simp_in.result = a_w | b_w;
         OP_XOR: simp_in.result = a_w ^ b_w;
         OP_NOT: simp_in.result = ~a_w;
         OP_SHL: simp_in.result = (amt >= AMT_BITS'(WORD_BITS)) ? '0 : a_w << amt;
         OP_SAR: simp_in.result = word_type'($signed(a_w) >>> sar_n);
         OP_ROL: simp_in.result = rol_val[2*WORD_BITS-1:WORD_BITS];
         OP_ROR: simp_in.result = ror_val[WORD_BITS-1:0];
         OP_CMP: begin
            simp_in.result   = '0;
            simp_in.is_less  = ($signed(a_w) < $signed(b_w));
            simp_in.is_equal = (a_w == b_w);
         end
         OP_MUL, OP_DIV, OP_MOD, OP_NOP: simp_in.result = '0;
      endcase
   end

   wia_mul u_mul (
      .clock   (clock),
      .enable  (adv),
      .a_in    (a_w),
      .b_in    (b_w),
      .product (mul_out)
   );

   wia_div u_div (
      .clock     (clock),
      .enable    (adv),
      .a_in      (a_w),
      .b_in      (b_w),
      .quotient  (div_quo),
      .remainder (div_rem),
      .div_zero  (div_dz)
   );

   // valid bits travel with the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vld_dly_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_dly_ff[0] <= s0_valid_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vld_dly_ff[i] <= vld_dly_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_dly_ff[0]   <= op;
         simp_dly_ff[0] <= simp_in;
         mul_dly_ff[0]  <= mul_out;
         for (int i = 1; i < DIV_LAT; i++) begin
            op_dly_ff[i]   <= op_dly_ff[i-1];
            simp_dly_ff[i] <= simp_dly_ff[i-1];
         end
         for (int i = 1; i < DIV_LAT - MUL_LAT; i++) begin
            mul_dly_ff[i] <= mul_dly_ff[i-1];
         end
      end
   end

   assign op_last = op_dly_ff[DIV_LAT-1];

   always_comb begin
      unique case (op_last)
         OP_MUL:  sel_word = mul_dly_ff[DIV_LAT-MUL_LAT-1];
         OP_DIV:  sel_word = div_quo;
         OP_MOD:  sel_word = div_rem;
         default: sel_word = simp_dly_ff[DIV_LAT-1].result;
      endcase
      full_res                   = FULL_BITS'(sel_word);
      rsp_data_in.result_low     = full_res[HALF_BITS-1:0];
      rsp_data_in.result_high    = full_res[FULL_BITS-1:HALF_BITS];
      rsp_data_in.is_less        = simp_dly_ff[DIV_LAT-1].is_less;
      rsp_data_in.is_equal       = simp_dly_ff[DIV_LAT-1].is_equal;
      rsp_data_in.divide_by_zero = ((op_last == OP_DIV) || (op_last == OP_MOD)) && div_dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_dly_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_cmp_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.is_less && rsp_data_ff.is_equal))
      else $error("is_less and is_equal both set");

   a_dz_no_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.divide_by_zero |->
         !rsp_data_ff.is_less && !rsp_data_ff.is_equal)
      else $error("divide by zero flagged on a compare");

   a_cmp_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.is_less || rsp_data_ff.is_equal) |->
         rsp_data_ff.result_low == '0 && rsp_data_ff.result_high == '0)
      else $error("compare result not zero");

   a_stall_holds_s0: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s0_valid_ff) && $stable(vld_dly_ff[DIV_LAT-1]))
      else $error("pipeline moved during a stall");

   a_out_from_pipe: assert property (@(posedge clock) disable iff (reset)
      adv && !vld_dly_ff[DIV_LAT-1] |=> !rsp_valid_ff)
      else $error("result without an item in the last stage");
`endif

endmodule

>>> test/wide_integer_alu_128_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wide_integer_alu_128_tb
// Self-checking bench for the 128-bit ALU: a directed table of edge cases,
// then random items under varying idle patterns and backpressure, with each
// result compared against the table or a behavioral model of every operation.
// ----------------------------------------------------------------------------
module wide_integer_alu_128_tb;
   import wia_pkg::*;

   localparam int LATENCY     = WORD_BITS + 3;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD   = 400;

   typedef logic [127:0] wide_type;

   typedef struct {
      alu_req_type req;
      bit          typed;
      alu_rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   alu_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   alu_rsp_type rsp_data;

   alu_rsp_type awaited_results[$];
   row_type     rows[$];
   int          mismatches;
   int          items_sent;
   int          results_seen;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_request;
   int          idle_cycles;
   int          op_count[16];

   localparam wide_type MIN_VAL = {1'b1, 127'd0};
   localparam wide_type MAX_VAL = {1'b0, {127{1'b1}}};
   localparam wide_type ALL_ONE = {128{1'b1}};

   wide_integer_alu_128 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic alu_req_type make_req(alu_op_type op, wide_type a, wide_type b,
                                            logic [7:0] amt);
      alu_req_type r;
      r.req_type     = op;
      r.a_low        = a[63:0];
      r.a_high       = a[127:64];
      r.b_low        = b[63:0];
      r.b_high       = b[127:64];
      r.shift_amount = amt;
      return r;
   endfunction

   function automatic alu_rsp_type make_rsp(wide_type res, logic lt, logic eq, logic dz);
      alu_rsp_type r;
      r.result_low     = res[63:0];
      r.result_high    = res[127:64];
      r.is_less        = lt;
      r.is_equal       = eq;
      r.divide_by_zero = dz;
      return r;
   endfunction

   // append one stimulus row to the directed table
   function automatic void add_row(alu_req_type req, bit typed, alu_rsp_type rsp);
      row_type row;
      row.req   = req;
      row.typed = typed;
      row.rsp   = rsp;
      rows.insert(rows.size(), row);
   endfunction

   function automatic alu_rsp_type compute_alu_result(alu_req_type r);
      wide_type   a, b, res, ma, mb, q, rm;
      logic       lt, eq, dz;
      int         n;
      a   = {r.a_high, r.a_low};
      b   = {r.b_high, r.b_low};
      res = '0;
      lt  = 1'b0;
      eq  = 1'b0;
      dz  = 1'b0;
      case (alu_op_type'(r.req_type))
         OP_ADD: res = a + b;
         OP_SUB: res = a - b;
         OP_NEG: res = -a;
         OP_MUL: res = a * b;
         OP_DIV, OP_MOD: begin
            if (b == '0) begin
               dz  = 1'b1;
               res = (r.req_type == OP_DIV) ? '0 : a;
            end else begin
               ma = a[127] ? -a : a;
               mb = b[127] ? -b : b;
               q  = ma / mb;
               rm = ma % mb;
               if (r.req_type == OP_DIV) res = (a[127] != b[127]) ? -q : q;
               else res = a[127] ? -rm : rm;
            end
         end
         OP_AND: res = a & b;
         OP_OR:  res = a | b;
         OP_XOR: res = a ^ b;
         OP_NOT: res = ~a;
         OP_SHL: res = (r.shift_amount >= 128) ? '0 : a << r.shift_amount;
         OP_SAR: begin
            n   = (r.shift_amount >= 128) ? 127 : r.shift_amount;
            res = $signed(a) >>> n;
         end
         OP_ROL: begin
            n   = r.shift_amount % 128;
            res = (n == 0) ? a : (a << n) | (a >> (128 - n));
         end
         OP_ROR: begin
            n   = r.shift_amount % 128;
            res = (n == 0) ? a : (a >> n) | (a << (128 - n));
         end
         OP_CMP: begin
            lt = $signed(a) < $signed(b);
            eq = (a == b);
         end
         default: res = '0;
      endcase
      return make_rsp(res, lt, eq, dz);
   endfunction

   function automatic wide_type random_word();
      wide_type w;
      w = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 7))
         0: w = wide_type'($urandom_range(0, 20));
         1: w = -wide_type'($urandom_range(1, 20));
         2: w = wide_type'({$urandom, $urandom});
         3: w = -wide_type'({$urandom, $urandom});
         4: begin
            case ($urandom_range(0, 3))
               0: w = MIN_VAL;
               1: w = MAX_VAL;
               2: w = ALL_ONE;
               default: w = '0;
            endcase
         end
         default: ;
      endcase
      return w;
   endfunction

   // offer one item and hold it until taken
   task automatic send_item(alu_req_type r, bit typed, alu_rsp_type typed_rsp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_results.insert(awaited_results.size(),
                             typed ? typed_rsp : compute_alu_result(r));
      op_count[r.req_type]++;
      items_sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result checker and receiver backpressure
   initial begin
      alu_rsp_type exp_rsp;
      int          hold_left;
      bit          hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $error("result with no item outstanding");
               mismatches++;
            end else begin
               exp_rsp = awaited_results.pop_front();
               if (rsp_data.result_low !== exp_rsp.result_low) begin
                  $error("result_low expected %h got %h", exp_rsp.result_low,
                         rsp_data.result_low);
                  mismatches++;
               end
               if (rsp_data.result_high !== exp_rsp.result_high) begin
                  $error("result_high expected %h got %h", exp_rsp.result_high,
                         rsp_data.result_high);
                  mismatches++;
               end
               if (rsp_data.is_less !== exp_rsp.is_less) begin
                  $error("is_less expected %b got %b", exp_rsp.is_less, rsp_data.is_less);
                  mismatches++;
               end
               if (rsp_data.is_equal !== exp_rsp.is_equal) begin
                  $error("is_equal expected %b got %b", exp_rsp.is_equal, rsp_data.is_equal);
                  mismatches++;
               end
               if (rsp_data.divide_by_zero !== exp_rsp.divide_by_zero) begin
                  $error("divide_by_zero expected %b got %b", exp_rsp.divide_by_zero,
                         rsp_data.divide_by_zero);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      alu_rsp_type none;
      alu_req_type r;
      int          phase_items[3];
      none         = make_rsp('0, 1'b0, 1'b0, 1'b0);
      mismatches   = 0;
      items_sent   = 0;
      results_seen = 0;
      hold_request = 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 76;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;

      add_row(make_req(OP_ADD, ALL_ONE, 128'd1, 8'd0), 1, make_rsp('0, 0, 0, 0));
      add_row(make_req(OP_ADD, MAX_VAL, 128'd1, 8'd0), 1, make_rsp(MIN_VAL, 0, 0, 0));
      add_row(make_req(OP_SUB, '0, 128'd1, 8'hff), 1, make_rsp(ALL_ONE, 0, 0, 0));
      add_row(make_req(OP_NEG, MIN_VAL, '0, 8'd0), 1, make_rsp(MIN_VAL, 0, 0, 0));
      add_row(make_req(OP_MUL, ALL_ONE, ALL_ONE, 8'd0), 1, make_rsp(128'd1, 0, 0, 0));
      add_row(make_req(OP_MUL, MAX_VAL, MIN_VAL, 8'd0), 0, none);
      add_row(make_req(OP_DIV, MAX_VAL, '0, 8'd0), 1, make_rsp('0, 0, 0, 1));
      add_row(make_req(OP_MOD, MIN_VAL, '0, 8'd0), 1, make_rsp(MIN_VAL, 0, 0, 1));
      add_row(make_req(OP_DIV, MIN_VAL, ALL_ONE, 8'd0), 1, make_rsp(MIN_VAL, 0, 0, 0));
      add_row(make_req(OP_MOD, MIN_VAL, ALL_ONE, 8'd0), 1, make_rsp('0, 0, 0, 0));
      add_row(make_req(OP_DIV, -128'd7, 128'd2, 8'd0), 0, none);
      add_row(make_req(OP_MOD, -128'd7, 128'd2, 8'd0), 0, none);
      add_row(make_req(OP_AND, ALL_ONE, MAX_VAL, 8'd0), 0, none);
      add_row(make_req(OP_OR,  MIN_VAL, 128'd5, 8'd0), 0, none);
      add_row(make_req(OP_XOR, ALL_ONE, MIN_VAL, 8'd0), 0, none);
      add_row(make_req(OP_NOT, '0, ALL_ONE, 8'd0), 1, make_rsp(ALL_ONE, 0, 0, 0));
      add_row(make_req(OP_SHL, ALL_ONE, '0, 8'd128), 1, make_rsp('0, 0, 0, 0));
      add_row(make_req(OP_SHL, 128'd1, '0, 8'd127), 1, make_rsp(MIN_VAL, 0, 0, 0));
      add_row(make_req(OP_SAR, MIN_VAL, '0, 8'd200), 1, make_rsp(ALL_ONE, 0, 0, 0));
      add_row(make_req(OP_SAR, MAX_VAL, '0, 8'd255), 1, make_rsp('0, 0, 0, 0));
      add_row(make_req(OP_ROL, MIN_VAL, '0, 8'd128), 1, make_rsp(MIN_VAL, 0, 0, 0));
      add_row(make_req(OP_ROR, 128'd1, '0, 8'd255), 0, none);
      add_row(make_req(OP_CMP, MIN_VAL, MIN_VAL, 8'd0), 1, make_rsp('0, 0, 1, 0));
      add_row(make_req(OP_CMP, ALL_ONE, 128'd1, 8'd0), 1, make_rsp('0, 1, 0, 0));
      add_row(make_req(OP_NOP, ALL_ONE, ALL_ONE, 8'hff), 1, make_rsp('0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].rsp);

      phase_items = '{500, 500, 400};
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 76;
            recv_idle_pct = 8;
         end else if (ph == 2) begin
            // let the pipe run dry, then stall the output while items keep coming
            drop_valid();
            wait (awaited_results.size() == 0);
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end
         for (int k = 0; k < phase_items[ph]; k++) begin
            r.req_type     = 4'($urandom_range(0, 15));
            {r.a_high, r.a_low} = random_word();
            {r.b_high, r.b_low} = random_word();
            r.shift_amount = 8'($urandom_range(0, 255));
            send_item(r, 0, none);
         end
      end
      drop_valid();

      wait (awaited_results.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);

      $display("Ran %0d items (%0d results) over all 16 opcodes, %0d divides and %0d modulos,",
               items_sent, results_seen, op_count[OP_DIV], op_count[OP_MOD]);
      $display("with sender and receiver idling in turn and one long output stall.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
